### src/ipd_pkg.sv
// ----------------------------------------------------------------------------
// ipd_pkg
// Shared types, character codes and helpers for the frame parser
// ----------------------------------------------------------------------------
package ipd_pkg;

    // configuration register
    localparam int           FRAME_LEN_W       = 12;
    localparam logic [11:0]  FRAME_LEN_RESET   = 12'd64;

    // character codes
    localparam logic [7:0]   CHR_PLUS          = 8'h2B;  // '+'
    localparam logic [7:0]   CHR_COLON         = 8'h3A;  // ':'
    localparam logic [7:0]   CHR_ZERO          = 8'h30;  // '0'
    localparam logic [7:0]   CHR_NINE          = 8'h39;  // '9'

    // one result item between parser core and output register
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       frame_end;
    } t_result;

    // expected header character after the plus sign, "IPD,"
    function automatic logic [7:0] header_char(input logic [1:0] pos);
        logic [7:0] c;
        case (pos)
            2'd0:    c = 8'h49;  // 'I'
            2'd1:    c = 8'h50;  // 'P'
            2'd2:    c = 8'h44;  // 'D'
            default: c = 8'h2C;  // ','
        endcase
        return c;
    endfunction

    // length * 10 + digit, wrapping at 16 bits
    function automatic logic [15:0] length_step(input logic [15:0] acc,
                                                input logic [3:0]  digit);
        logic [15:0] r;
        r = (acc << 3) + (acc << 1) + {12'd0, digit};
        return r;
    endfunction

endpackage

### src/ipd_parse_core.sv
// ----------------------------------------------------------------------------
// ipd_parse_core
// Input register, frame length register and per-byte parse state machine
// ----------------------------------------------------------------------------
module ipd_parse_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input byte stream
    input  logic              i_s_valid,
    output logic              o_s_ready,
    input  logic [7:0]        i_s_byte,
    // configuration write
    input  logic              i_cfg_valid,
    input  logic [11:0]       i_cfg_data,
    // downstream slot can take a result this cycle
    input  logic              i_slot_free,
    // result toward output register
    output logic              o_res_valid,
    output ipd_pkg::t_result  o_res
);

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_MATCH   = 2'd1;
    localparam logic [1:0] PH_LENGTH  = 2'd2;
    localparam logic [1:0] PH_PAYLOAD = 2'd3;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic [11:0] r_frame_len;
    logic [1:0]  r_phase,  n_phase;
    logic [1:0]  r_hpos,   n_hpos;
    logic [15:0] r_acc,    n_acc;
    logic [11:0] r_cnt,    n_cnt;

    logic        proceed;
    logic        is_digit;
    logic [12:0] cnt_next;
    logic        last;

    // the held byte is processed unless it is a payload byte with no free slot
    assign proceed   = r_in_valid && (r_phase != PH_PAYLOAD || i_slot_free);
    assign o_s_ready = !r_in_valid || proceed;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_ready) begin
            r_in_valid <= i_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_ready) begin
            r_in_byte <= i_s_byte;
        end
    end

    // frame length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_len <= ipd_pkg::FRAME_LEN_RESET;
        end else if (i_cfg_valid) begin
            r_frame_len <= i_cfg_data;
        end
    end

    // per-byte decode
    assign is_digit = (r_in_byte >= ipd_pkg::CHR_ZERO) && (r_in_byte <= ipd_pkg::CHR_NINE);
    assign cnt_next = {1'b0, r_cnt} + 13'd1;
    assign last     = (cnt_next == r_acc[12:0] && r_acc[15:13] == 3'd0) || cnt_next[12];

    always_comb begin
        n_phase     = r_phase;
        n_hpos      = r_hpos;
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        o_res_valid = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                if (r_in_byte == ipd_pkg::CHR_PLUS) begin
                    n_phase = PH_MATCH;
                    n_hpos  = 2'd0;
                end
            end
            PH_MATCH: begin
                if (r_in_byte == ipd_pkg::header_char(r_hpos)) begin
                    if (r_hpos == 2'd3) begin
                        n_hpos  = 2'd0;
                        n_phase = PH_LENGTH;
                        n_acc   = 16'd0;
                    end else begin
                        n_hpos = r_hpos + 2'd1;
                    end
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_LENGTH: begin
                if (is_digit) begin
                    n_acc = ipd_pkg::length_step(r_acc, r_in_byte[3:0]);
                end else if (r_in_byte == ipd_pkg::CHR_COLON && r_frame_len != 12'd0 &&
                             r_acc == {4'd0, r_frame_len}) begin
                    n_phase = PH_PAYLOAD;
                    n_cnt   = 12'd0;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                o_res_valid = proceed;
                n_cnt       = cnt_next[11:0];
                if (last) begin
                    n_phase = PH_IDLE;
                end
            end
        endcase
    end

    assign o_res.payload_byte = r_in_byte;
    assign o_res.frame_end    = last;

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_hpos  <= 2'd0;
            r_acc   <= 16'd0;
            r_cnt   <= 12'd0;
        end else if (proceed) begin
            r_phase <= n_phase;
            r_hpos  <= n_hpos;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
        end
    end

    // a payload only runs for a length that fits the 12-bit register
    a_payload_len_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_acc[15:12] == 4'd0)
        else $error("payload entered with out-of-range length");

    // the byte count stays below the accepted length during a payload
    a_count_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> {4'd0, r_cnt} < r_acc)
        else $error("payload count reached frame length without ending");

    // results come only from a held byte in the payload phase
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> r_in_valid && r_phase == PH_PAYLOAD)
        else $error("result without a held payload byte");

endmodule

### src/ipd_out_stage.sv
// ----------------------------------------------------------------------------
// ipd_out_stage
// Result register toward the master-side stream
// ----------------------------------------------------------------------------
module ipd_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // result from parser core
    input  logic              i_load,
    input  ipd_pkg::t_result  i_res,
    output logic              o_slot_free,
    // master-side stream
    output logic              o_m_valid,
    input  logic              i_m_ready,
    output logic [7:0]        o_m_data,
    output logic              o_m_last
);

    logic             r_valid;
    ipd_pkg::t_result r_res;

    // slot is free when empty or being drained this cycle
    assign o_slot_free = !r_valid || i_m_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_m_valid = r_valid;
    assign o_m_data  = r_res.payload_byte;
    assign o_m_last  = r_res.frame_end;

    // a new result never overwrites one that is still stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_load && r_valid && !i_m_ready))
        else $error("result register overwritten while stalled");

    // a loaded result is offered on the next cycle
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> r_valid)
        else $error("loaded result not presented");

endmodule

### src/ipd_frame_parser_top.sv
// ----------------------------------------------------------------------------
// ipd_frame_parser_top
// "+IPD,<len>:<payload>" byte stream parser, payload bytes streamed out
// ----------------------------------------------------------------------------
//  channel   direction  ports                          contents
//  s_axis    in         i_s_axis_t{valid,data}, o_..   one received byte
//  m_axis    out        o_m_axis_t{valid,data,last}    payload byte, tlast on final
//  cfg       in         i_cfg_{valid,data}, o_cfg_ready frame length, 12 bits
//
//  One byte per cycle while no result is stalled: a byte is held in the input
//  register, then the parse state and the result register update together.
//  Bytes that make no result still pass through the state machine.
//  Reset (synchronous) clears the state to idle and frame length to 64.
//  A stalled result blocks only payload bytes behind it.
// ----------------------------------------------------------------------------
module ipd_frame_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave-side stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    // master-side stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] payload_byte
    output logic        o_m_axis_tlast,   // frame_end
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [11:0] i_cfg_data        // [11:0] frame_length
);

    logic             slot_free;
    logic             res_valid;
    ipd_pkg::t_result res;

    assign o_cfg_ready = 1'b1;

    // parser core
    ipd_parse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_valid   (i_s_axis_tvalid),
        .o_s_ready   (o_s_axis_tready),
        .i_s_byte    (i_s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_slot_free (slot_free),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register
    ipd_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (res_valid),
        .i_res       (res),
        .o_slot_free (slot_free),
        .o_m_valid   (o_m_axis_tvalid),
        .i_m_ready   (i_m_axis_tready),
        .o_m_data    (o_m_axis_tdata),
        .o_m_last    (o_m_axis_tlast)
    );

endmodule
